/* src/compressor_hysteresis_controller_core_assert.svh */
// Assertion macros used by the port checker of the compressor controller.
// Expects clk and arst_n in the scope of each use.
`ifndef COMPRESSOR_HYSTERESIS_CONTROLLER_CORE_ASSERT_SVH
`define COMPRESSOR_HYSTERESIS_CONTROLLER_CORE_ASSERT_SVH

// Same-cycle implication, off during reset.
`define CHC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("compressor controller port check failed");

// Next-cycle implication, off during reset.
`define CHC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("compressor controller port check failed");

`endif

/* src/chc_pkg.sv */
`timescale 1ns / 1ps
// Types and codes of the compressor hysteresis controller.
// No dependencies; every other .sv file refers to it by scoped names.
package chc_pkg;

	localparam int unsigned PressW = 14;
	localparam int unsigned RateW  = 10;
	localparam int unsigned CfgIdxW = 3;

	// Configuration register indexes
	localparam logic [CfgIdxW-1:0] CFG_LOW_THRESHOLD    = 3'd0;
	localparam logic [CfgIdxW-1:0] CFG_HIGH_THRESHOLD   = 3'd1;
	localparam logic [CfgIdxW-1:0] CFG_QUIET_BAND       = 3'd2;
	localparam logic [CfgIdxW-1:0] CFG_PRESSURE_CEILING = 3'd3;
	localparam logic [CfgIdxW-1:0] CFG_RISE_RATE        = 3'd4;
	localparam logic [CfgIdxW-1:0] CFG_DRAIN_RATE       = 3'd5;

	// Sound commands
	localparam logic [2:0] SND_NONE   = 3'd0;
	localparam logic [2:0] SND_DIRECT = 3'd1;
	localparam logic [2:0] SND_MIN    = 3'd2;
	localparam logic [2:0] SND_MAX    = 3'd3;
	localparam logic [2:0] SND_STOP   = 3'd4;

	// Needle commands
	localparam logic [1:0] NDL_NONE  = 2'd0;
	localparam logic [1:0] NDL_RISE  = 2'd1;
	localparam logic [1:0] NDL_HOLD  = 2'd2;
	localparam logic [1:0] NDL_DRAIN = 2'd3;

	typedef enum logic [1:0] {
		MODE_OFF    = 2'd0,
		MODE_RUN    = 2'd1,
		MODE_IDLE   = 2'd2,
		MODE_DIRECT = 2'd3
	} mode_t;

	typedef struct packed {
		logic              breaker_locked;
		logic              auto_switch_on;
		logic              direct_switch_on;
		logic [PressW-1:0] pressure_now;
		logic              brake_pipe_rising;
		logic              brake_cylinder_rising;
		logic              cylinder_one_rising;
		logic              cylinder_two_rising;
	} in_item_t;

	typedef struct packed {
		logic [2:0] sound_cmd;
		logic [1:0] needle_cmd;
		logic [1:0] mode_now;
	} out_item_t;

	typedef struct packed {
		logic [PressW-1:0] low_threshold;
		logic [PressW-1:0] high_threshold;
		logic [PressW-1:0] quiet_band;
		logic [PressW-1:0] pressure_ceiling;
		logic [RateW-1:0]  rise_rate;
		logic [RateW-1:0]  drain_rate;
	} cfg_t;

	typedef struct packed {
		mode_t mode;
		logic  quiet_stop;
	} state_t;

endpackage

/* src/chc_cfg.sv */
`timescale 1ns / 1ps
// Configuration register file of the compressor controller.
// Depends on chc_pkg.
module chc_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [chc_pkg::CfgIdxW-1:0]       wr_index,
	input  logic [chc_pkg::PressW-1:0]        wr_data,
	output chc_pkg::cfg_t                     cfg
);

	chc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.low_threshold    <= 14'd7800;
			cfg_q.high_threshold   <= 14'd9000;
			cfg_q.quiet_band       <= 14'd800;
			cfg_q.pressure_ceiling <= 14'd10000;
			cfg_q.rise_rate        <= 10'd54;
			cfg_q.drain_rate       <= 10'd150;
		end else if (wr_en) begin
			unique case (wr_index)
				chc_pkg::CFG_LOW_THRESHOLD:    cfg_q.low_threshold    <= wr_data;
				chc_pkg::CFG_HIGH_THRESHOLD:   cfg_q.high_threshold   <= wr_data;
				chc_pkg::CFG_QUIET_BAND:       cfg_q.quiet_band       <= wr_data;
				chc_pkg::CFG_PRESSURE_CEILING: cfg_q.pressure_ceiling <= wr_data;
				chc_pkg::CFG_RISE_RATE: begin
					cfg_q.rise_rate <= wr_data[chc_pkg::RateW-1:0];
				end
				chc_pkg::CFG_DRAIN_RATE: begin
					cfg_q.drain_rate <= wr_data[chc_pkg::RateW-1:0];
				end
				default: ; // drop writes past the register list
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* src/chc_step.sv */
`timescale 1ns / 1ps
// Next-mode and command logic for one item of the compressor controller.
// Purely combinational; depends on chc_pkg.
module chc_step (
	input  chc_pkg::in_item_t  item,
	input  chc_pkg::state_t    state,
	input  chc_pkg::cfg_t      cfg,
	output chc_pkg::state_t    state_next,
	output chc_pkg::out_item_t result
);

	logic                     rising;
	logic                     below_low;
	logic                     near_low;
	logic                     deep_quiet;
	logic                     above_high;
	logic [chc_pkg::PressW:0] p_plus_band;
	logic [2:0]               engage_snd;
	logic                     engage_quiet;
	logic [2:0]               snd;
	logic [1:0]               ndl;
	chc_pkg::mode_t           nxt;
	logic                     quiet_nxt;

	assign rising = item.brake_pipe_rising | item.brake_cylinder_rising
		| item.cylinder_one_rising | item.cylinder_two_rising;

	// p > low - band, rewritten as p + band > low to stay unsigned
	assign p_plus_band  = {1'b0, item.pressure_now} + {1'b0, cfg.quiet_band};
	assign near_low     = p_plus_band > {1'b0, cfg.low_threshold};
	assign below_low    = item.pressure_now < cfg.low_threshold;
	assign deep_quiet   = item.pressure_now < cfg.quiet_band;
	assign above_high   = item.pressure_now > cfg.high_threshold;
	assign engage_snd   = near_low ? chc_pkg::SND_MIN : chc_pkg::SND_MAX;
	assign engage_quiet = near_low | deep_quiet;

	always_comb begin
		snd       = chc_pkg::SND_NONE;
		ndl       = chc_pkg::NDL_NONE;
		nxt       = state.mode;
		quiet_nxt = state.quiet_stop;
		unique case (state.mode)
			chc_pkg::MODE_OFF: begin
				if (item.breaker_locked) begin
					if (item.direct_switch_on) begin
						snd = chc_pkg::SND_DIRECT;
						ndl = chc_pkg::NDL_RISE;
						nxt = chc_pkg::MODE_DIRECT;
					end else if (item.auto_switch_on) begin
						if (below_low) begin
							snd       = engage_snd;
							quiet_nxt = engage_quiet;
							ndl       = chc_pkg::NDL_RISE;
							nxt       = chc_pkg::MODE_RUN;
						end else begin
							ndl = chc_pkg::NDL_HOLD;
							nxt = chc_pkg::MODE_IDLE;
						end
					end
				end
			end
			chc_pkg::MODE_RUN: begin
				if (!item.breaker_locked) begin
					snd = chc_pkg::SND_STOP;
					ndl = chc_pkg::NDL_HOLD;
					nxt = chc_pkg::MODE_OFF;
				end else if (item.direct_switch_on) begin
					snd = chc_pkg::SND_DIRECT;
					ndl = chc_pkg::NDL_RISE;
					nxt = chc_pkg::MODE_DIRECT;
				end else if (item.auto_switch_on) begin
					if (above_high) begin
						snd = state.quiet_stop ? chc_pkg::SND_NONE : chc_pkg::SND_STOP;
						ndl = chc_pkg::NDL_HOLD;
						nxt = chc_pkg::MODE_IDLE;
					end
				end else begin
					snd = chc_pkg::SND_STOP;
					ndl = chc_pkg::NDL_HOLD;
					nxt = chc_pkg::MODE_OFF;
				end
			end
			chc_pkg::MODE_IDLE: begin
				if (!item.breaker_locked) begin
					nxt = chc_pkg::MODE_OFF;
				end else if (item.direct_switch_on) begin
					snd = chc_pkg::SND_DIRECT;
					ndl = chc_pkg::NDL_RISE;
					nxt = chc_pkg::MODE_DIRECT;
				end else if (item.auto_switch_on) begin
					if (below_low) begin
						snd       = engage_snd;
						quiet_nxt = engage_quiet;
						ndl       = chc_pkg::NDL_RISE;
						nxt       = chc_pkg::MODE_RUN;
					end
				end else begin
					nxt = chc_pkg::MODE_OFF;
				end
			end
			default: begin
				if (!item.breaker_locked) begin
					snd = chc_pkg::SND_STOP;
					ndl = chc_pkg::NDL_HOLD;
					nxt = chc_pkg::MODE_OFF;
				end else if (!item.direct_switch_on) begin
					if (item.auto_switch_on) begin
						if (below_low) begin
							snd       = engage_snd;
							quiet_nxt = engage_quiet;
							ndl       = chc_pkg::NDL_RISE;
							nxt       = chc_pkg::MODE_RUN;
						end else begin
							ndl = chc_pkg::NDL_HOLD;
							nxt = chc_pkg::MODE_IDLE;
						end
					end else begin
						snd = chc_pkg::SND_STOP;
						ndl = chc_pkg::NDL_HOLD;
						nxt = chc_pkg::MODE_OFF;
					end
				end
			end
		endcase
		// compressor stopped: needle follows the other circuits
		if (nxt == chc_pkg::MODE_OFF || nxt == chc_pkg::MODE_IDLE) begin
			ndl = rising ? chc_pkg::NDL_DRAIN : chc_pkg::NDL_HOLD;
		end
	end

	assign state_next.mode       = nxt;
	assign state_next.quiet_stop = quiet_nxt;
	assign result.sound_cmd      = snd;
	assign result.needle_cmd     = ndl;
	assign result.mode_now       = nxt;

endmodule

/* src/compressor_hysteresis_controller_core.sv */
`timescale 1ns / 1ps
// Top level of the compressor hysteresis controller: input stage, mode state,
// result stage. Depends on chc_pkg, chc_cfg and chc_step.
//
//  channel | signals                          | direction | moves
//  --------+----------------------------------+-----------+-------------------------
//  in      | in_valid, in_ready, in_item      | into core | one tick of switch data
//  out     | out_valid, out_ready, out_item   | out       | sound, needle, new mode
//  cfg     | cfg_valid, cfg_ready, cfg_index, | into core | one register write
//          | cfg_data                         |           |
//
// An accepted item waits in the input register; then the mode logic runs and
// the result register loads.
// One item is accepted every cycle while out_ready stays high; the input
// register and the result register each hold one item under a stall.
// Reset (arst_n low) empties both stages, returns the mode to off, clears
// the quiet-stop flag and loads the register defaults.
// cfg_ready is always high; an accepted write is registered in chc_cfg.
module compressor_hysteresis_controller_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  chc_pkg::in_item_t             in_item,
	output logic                          out_valid,
	input  logic                          out_ready,
	output chc_pkg::out_item_t            out_item,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [chc_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [chc_pkg::PressW-1:0]    cfg_data
);

	chc_pkg::in_item_t  item_s1;
	logic               valid_s1;
	chc_pkg::out_item_t result_s2;
	logic               valid_s2;
	chc_pkg::state_t    state_q;
	chc_pkg::state_t    state_next;
	chc_pkg::out_item_t result;
	chc_pkg::cfg_t      cfg;
	logic               advance;

	// Registers are always writable.
	assign cfg_ready = 1'b1;

	chc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	chc_step u_step (
		.item       (item_s1),
		.state      (state_q),
		.cfg        (cfg),
		.state_next (state_next),
		.result     (result)
	);

	// Move the staged item into the result register when that slot is free
	// or its item leaves this cycle.
	assign advance  = valid_s1 & (~valid_s2 | out_ready);
	// Take a new item when the input register is empty or drains now.
	assign in_ready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready & in_valid) begin
			item_s1 <= in_item;
		end
	end

	// Mode state advances exactly once per item, when its result is latched.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode       <= chc_pkg::MODE_OFF;
			state_q.quiet_stop <= 1'b0;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	// Hold the result while the consumer stalls.
	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign out_valid = valid_s2;
	assign out_item  = result_s2;

endmodule

/* src/chc_port_checker.sv */
`timescale 1ns / 1ps
// Port-level checks of the compressor controller, bound to the top level.
// Depends on chc_pkg and compressor_hysteresis_controller_core_assert.svh.
`include "compressor_hysteresis_controller_core_assert.svh"

module chc_port_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input chc_pkg::out_item_t out_item
);

	logic stopped_mode;
	logic drain_or_hold;
	logic direct_rise;

	// compressor stopped in the new mode
	assign stopped_mode  = (out_item.mode_now == chc_pkg::MODE_OFF)
		|| (out_item.mode_now == chc_pkg::MODE_IDLE);
	assign drain_or_hold = (out_item.needle_cmd == chc_pkg::NDL_HOLD)
		|| (out_item.needle_cmd == chc_pkg::NDL_DRAIN);
	assign direct_rise   = (out_item.mode_now == chc_pkg::MODE_DIRECT)
		&& (out_item.needle_cmd == chc_pkg::NDL_RISE);

	`CHC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_item))
	`CHC_ASSERT_NOW(a_sound_range, out_valid, out_item.sound_cmd <= chc_pkg::SND_STOP)
	`CHC_ASSERT_NOW(a_stopped_needle, out_valid && stopped_mode, drain_or_hold)
	`CHC_ASSERT_NOW(a_direct_on, out_valid && out_item.sound_cmd == chc_pkg::SND_DIRECT, direct_rise)

endmodule

bind compressor_hysteresis_controller_core chc_port_checker u_chc_port_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_item  (out_item)
);
